### design/xmodem_checksum_sender_core_macros.svh
// ----------------------------------------------------------------------------
// XMODEM checksum sender - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_SENDER_CORE_MACROS_SVH
`define XMODEM_CHECKSUM_SENDER_CORE_MACROS_SVH

// same-cycle implication
`define XCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/xcs_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM checksum sender - package
// Widths, protocol characters, function and status codes, shared types.
// ----------------------------------------------------------------------------
package xcs_pkg;

    localparam int BLOCK_DATA_BYTES_DEF = 128;

    localparam int FUNC_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int TLEN_W     = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_W    = 18;
    localparam int TOTAL_W    = 24;
    localparam int RUN_W      = 8;
    localparam int STATUS_W   = 3;

    localparam logic [FUNC_W-1:0] FUNC_START    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PAYLOAD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RX_BYTE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TX_SLOT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LINK_ERR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT     = 1'd1;

    localparam logic [RUN_W-1:0] ERROR_LIMIT_RESET = 8'd10;

    localparam logic [STATUS_W-1:0] STATUS_BUSY      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TX_ERROR  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 3'd4;

    localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] CH_CAN = 8'h18;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_NAK,
        PH_LOAD,
        PH_SEND,
        PH_WAIT_RESP,
        PH_CAN_SEEN,
        PH_EOT_SEND,
        PH_EOT_WAIT
    } phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] rx_byte;
    } xcs_item_t;

    typedef struct packed {
        logic                  write;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } xcs_cfg_t;

    typedef struct packed {
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                tx_last;
        logic                need_payload;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  success_count;
        logic [TOTAL_W-1:0]  total_errors;
        logic [COUNT_W-1:0]  last_error_block;
        logic [RUN_W-1:0]    last_error_run;
    } xcs_result_t;

endpackage

### design/xcs_ram.sv
// ----------------------------------------------------------------------------
// XMODEM checksum sender - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module xcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/xcs_engine.sv
// ----------------------------------------------------------------------------
// XMODEM checksum sender - protocol engine
// Phase machine, block buffer, counters and the per-item result.
// ----------------------------------------------------------------------------
`include "xmodem_checksum_sender_core_macros.svh"

module xcs_engine #(
    parameter int BLOCK_DATA_BYTES = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  xcs_pkg::xcs_item_t  item,
    input  xcs_pkg::xcs_cfg_t   cfg,
    output xcs_pkg::xcs_result_t result
);

    import xcs_pkg::*;

    localparam int LEN_W  = $clog2(BLOCK_DATA_BYTES + 1);
    localparam int IDX_W  = $clog2(BLOCK_DATA_BYTES + 4);
    localparam int ADDR_W = $clog2(BLOCK_DATA_BYTES);

    localparam logic [IDX_W-1:0]  HDR_LEN   = IDX_W'(3);
    localparam logic [IDX_W-1:0]  SUM_SLOT  = IDX_W'(BLOCK_DATA_BYTES + 3);
    localparam logic [TLEN_W-1:0] BLOCK_LEN = TLEN_W'(BLOCK_DATA_BYTES);

    logic [TLEN_W-1:0]   transfer_length_reg;
    logic [RUN_W-1:0]    error_limit_reg;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  block_count_reg, block_count_next;
    logic [TLEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]    chunk_length_reg, chunk_length_next;
    logic [LEN_W-1:0]    load_index_reg, load_index_next;
    logic [IDX_W-1:0]    send_index_reg, send_index_next;
    logic [BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic [RUN_W-1:0]    error_run_reg, error_run_next;
    logic [COUNT_W-1:0]  acked_blocks_reg, acked_blocks_next;
    logic [TOTAL_W-1:0]  nak_total_reg, nak_total_next;
    logic [COUNT_W-1:0]  last_nak_block_reg, last_nak_block_next;
    logic [RUN_W-1:0]    last_nak_run_reg, last_nak_run_next;
    logic [STATUS_W-1:0] end_status_reg, end_status_next;

    logic [RUN_W-1:0]    run_bumped;
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [IDX_W-1:0]    data_off;
    logic [IDX_W-1:0]    rd_off;
    logic                data_slot;
    logic                tx_valid_c;
    logic [BYTE_W-1:0]   tx_byte_c;
    logic                tx_last_c;

    assign run_bumped = (error_run_reg == '1) ? error_run_reg : error_run_reg + RUN_W'(1);
    assign data_off   = send_index_reg - HDR_LEN;
    assign rd_off     = send_index_next - HDR_LEN;
    assign data_slot  = (send_index_reg >= HDR_LEN) && (send_index_reg < SUM_SLOT);

    xcs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BLOCK_DATA_BYTES)
    ) u_block_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_index_reg[ADDR_W-1:0]),
        .wdata (item.payload_byte),
        .raddr (rd_off[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        block_count_next    = block_count_reg;
        bytes_left_next     = bytes_left_reg;
        chunk_length_next   = chunk_length_reg;
        load_index_next     = load_index_reg;
        send_index_next     = send_index_reg;
        running_sum_next    = running_sum_reg;
        error_run_next      = error_run_reg;
        acked_blocks_next   = acked_blocks_reg;
        nak_total_next      = nak_total_reg;
        last_nak_block_next = last_nak_block_reg;
        last_nak_run_next   = last_nak_run_reg;
        end_status_next     = end_status_reg;
        ram_we              = 1'b0;
        if (step)
        begin
            case (item.func)
                FUNC_START:
                begin
                    end_status_next     = STATUS_BUSY;
                    acked_blocks_next   = '0;
                    nak_total_next      = '0;
                    last_nak_block_next = '0;
                    last_nak_run_next   = '0;
                    error_run_next      = '0;
                    block_count_next    = '0;
                    bytes_left_next     = transfer_length_reg;
                    if (transfer_length_reg == '0)
                    begin
                        end_status_next = STATUS_BAD_LEN;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_NAK;
                    end
                end
                FUNC_PAYLOAD:
                begin
                    if (phase_reg == PH_LOAD)
                    begin
                        ram_we          = load_index_reg < chunk_length_reg;
                        load_index_next = load_index_reg + LEN_W'(1);
                        if (load_index_next >= chunk_length_reg)
                        begin
                            send_index_next  = '0;
                            running_sum_next = '0;
                            phase_next       = PH_SEND;
                        end
                    end
                end
                FUNC_RX_BYTE:
                begin
                    case (phase_reg)
                        PH_WAIT_NAK:
                        begin
                            if (item.rx_byte == CH_NAK)
                            begin
                                block_count_next  = COUNT_W'(1);
                                error_run_next    = '0;
                                chunk_length_next = (bytes_left_reg >= BLOCK_LEN) ?
                                    LEN_W'(BLOCK_DATA_BYTES) : bytes_left_reg[LEN_W-1:0];
                                load_index_next   = '0;
                                phase_next        = PH_LOAD;
                            end
                            else
                            begin
                                error_run_next = run_bumped;
                                if (run_bumped > error_limit_reg)
                                begin
                                    end_status_next = STATUS_TX_ERROR;
                                    phase_next      = PH_IDLE;
                                end
                            end
                        end
                        PH_WAIT_RESP:
                        begin
                            if (item.rx_byte == CH_ACK)
                            begin
                                acked_blocks_next = acked_blocks_reg + COUNT_W'(1);
                                block_count_next  = block_count_reg + COUNT_W'(1);
                                bytes_left_next   = bytes_left_reg - TLEN_W'(chunk_length_reg);
                                error_run_next    = '0;
                                if (bytes_left_next == '0)
                                begin
                                    phase_next = PH_EOT_SEND;
                                end
                                else
                                begin
                                    chunk_length_next = (bytes_left_next >= BLOCK_LEN) ?
                                        LEN_W'(BLOCK_DATA_BYTES) : bytes_left_next[LEN_W-1:0];
                                    load_index_next   = '0;
                                    phase_next        = PH_LOAD;
                                end
                            end
                            else if (item.rx_byte == CH_CAN)
                            begin
                                phase_next = PH_CAN_SEEN;
                            end
                            else if (item.rx_byte == CH_NAK)
                            begin
                                error_run_next      = run_bumped;
                                nak_total_next      = (nak_total_reg == '1) ?
                                    nak_total_reg : nak_total_reg + TOTAL_W'(1);
                                last_nak_block_next = block_count_reg;
                                last_nak_run_next   = run_bumped;
                                if (run_bumped > error_limit_reg)
                                begin
                                    end_status_next = STATUS_TX_ERROR;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    send_index_next  = '0;
                                    running_sum_next = '0;
                                    phase_next       = PH_SEND;
                                end
                            end
                        end
                        PH_CAN_SEEN:
                        begin
                            if (item.rx_byte == CH_CAN)
                            begin
                                end_status_next = STATUS_CANCELLED;
                                phase_next      = PH_IDLE;
                            end
                            else
                            begin
                                send_index_next  = '0;
                                running_sum_next = '0;
                                phase_next       = PH_SEND;
                            end
                        end
                        PH_EOT_WAIT:
                        begin
                            if (item.rx_byte == CH_ACK)
                            begin
                                end_status_next = STATUS_DONE;
                                phase_next      = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_EOT_SEND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_TX_SLOT:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        if (data_slot)
                        begin
                            running_sum_next = running_sum_reg + tx_byte_c;
                        end
                        if (tx_last_c)
                        begin
                            phase_next = PH_WAIT_RESP;
                        end
                        else
                        begin
                            send_index_next = send_index_reg + IDX_W'(1);
                        end
                    end
                    else if (phase_reg == PH_EOT_SEND)
                    begin
                        phase_next = PH_EOT_WAIT;
                    end
                end
                FUNC_LINK_ERR:
                begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_WAIT_NAK)
                    begin
                        end_status_next = STATUS_TX_ERROR;
                        phase_next      = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        tx_valid_c = 1'b0;
        tx_byte_c  = '0;
        tx_last_c  = 1'b0;
        if (step && item.func == FUNC_TX_SLOT)
        begin
            case (phase_reg)
                PH_SEND:
                begin
                    tx_valid_c = 1'b1;
                    if (send_index_reg == IDX_W'(0))
                    begin
                        tx_byte_c = CH_SOH;
                    end
                    else if (send_index_reg == IDX_W'(1))
                    begin
                        tx_byte_c = block_count_reg[BYTE_W-1:0];
                    end
                    else if (send_index_reg == IDX_W'(2))
                    begin
                        tx_byte_c = ~block_count_reg[BYTE_W-1:0];
                    end
                    else if (data_slot)
                    begin
                        tx_byte_c = (data_off >= IDX_W'(chunk_length_reg)) ? '0 : ram_rdata;
                    end
                    else
                    begin
                        tx_byte_c = running_sum_reg;
                        tx_last_c = 1'b1;
                    end
                end
                PH_EOT_SEND:
                begin
                    tx_valid_c = 1'b1;
                    tx_byte_c  = CH_EOT;
                    tx_last_c  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        result.tx_valid         = tx_valid_c;
        result.tx_byte          = tx_byte_c;
        result.tx_last          = tx_last_c;
        result.need_payload     = phase_next == PH_LOAD;
        result.status           = (phase_next == PH_IDLE) ? end_status_next : STATUS_BUSY;
        result.success_count    = acked_blocks_next;
        result.total_errors     = nak_total_next;
        result.last_error_block = last_nak_block_next;
        result.last_error_run   = last_nak_run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transfer_length_reg <= '0;
            error_limit_reg     <= ERROR_LIMIT_RESET;
        end
        else if (cfg.write)
        begin
            case (cfg.index)
                CFG_TRANSFER_LENGTH: transfer_length_reg <= cfg.data[TLEN_W-1:0];
                CFG_ERROR_LIMIT:     error_limit_reg     <= cfg.data[RUN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            block_count_reg    <= '0;
            bytes_left_reg     <= '0;
            chunk_length_reg   <= '0;
            load_index_reg     <= '0;
            send_index_reg     <= '0;
            running_sum_reg    <= '0;
            error_run_reg      <= '0;
            acked_blocks_reg   <= '0;
            nak_total_reg      <= '0;
            last_nak_block_reg <= '0;
            last_nak_run_reg   <= '0;
            end_status_reg     <= STATUS_BUSY;
        end
        else
        begin
            phase_reg          <= phase_next;
            block_count_reg    <= block_count_next;
            bytes_left_reg     <= bytes_left_next;
            chunk_length_reg   <= chunk_length_next;
            load_index_reg     <= load_index_next;
            send_index_reg     <= send_index_next;
            running_sum_reg    <= running_sum_next;
            error_run_reg      <= error_run_next;
            acked_blocks_reg   <= acked_blocks_next;
            nak_total_reg      <= nak_total_next;
            last_nak_block_reg <= last_nak_block_next;
            last_nak_run_reg   <= last_nak_run_next;
            end_status_reg     <= end_status_next;
        end
    end

    `XCS_ASSERT_IMP(a_load_in_range, phase_reg == PH_LOAD, load_index_reg < chunk_length_reg, "load index past chunk")
    `XCS_ASSERT_IMP(a_chunk_nonzero, phase_reg == PH_LOAD || phase_reg == PH_SEND || phase_reg == PH_WAIT_RESP, chunk_length_reg != '0, "empty chunk in block phase")
    `XCS_ASSERT_IMP(a_send_bound, phase_reg == PH_SEND, send_index_reg <= SUM_SLOT, "send index past checksum")
    `XCS_ASSERT_NEXT(a_link_error_ends, step && item.func == FUNC_LINK_ERR && phase_reg != PH_IDLE && phase_reg != PH_WAIT_NAK, phase_reg == PH_IDLE && end_status_reg == STATUS_TX_ERROR, "link error did not end transfer")

endmodule

### design/xmodem_checksum_sender_core.sv
// ----------------------------------------------------------------------------
// XMODEM checksum sender - top level
// Input register, protocol engine and result register with valid/ready.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless out_ready stalls it, and returns
// one result per item through the input register, then the result register.
// The engine handles each item as it advances; the block buffer is a
// single-port-read RAM whose address follows the next send position, so the
// data byte for a transmit slot is ready when the slot arrives. The buffer
// needs no clearing pass after reset. Write configuration only while idle.
`include "xmodem_checksum_sender_core_macros.svh"

module xmodem_checksum_sender_core #(
    parameter int BLOCK_DATA_BYTES = xcs_pkg::BLOCK_DATA_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [xcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [xcs_pkg::FUNC_W-1:0]      func,
    input  logic [xcs_pkg::BYTE_W-1:0]      payload_byte,
    input  logic [xcs_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            tx_valid,
    output logic [xcs_pkg::BYTE_W-1:0]      tx_byte,
    output logic                            tx_last,
    output logic                            need_payload,
    output logic [xcs_pkg::STATUS_W-1:0]    status,
    output logic [xcs_pkg::COUNT_W-1:0]     success_count,
    output logic [xcs_pkg::TOTAL_W-1:0]     total_errors,
    output logic [xcs_pkg::COUNT_W-1:0]     last_error_block,
    output logic [xcs_pkg::RUN_W-1:0]       last_error_run
);

    import xcs_pkg::*;

    logic        in_valid_reg, in_valid_next;
    xcs_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    xcs_result_t result_reg;
    xcs_result_t result_c;
    xcs_cfg_t    cfg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    xcs_engine #(
        .BLOCK_DATA_BYTES (BLOCK_DATA_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.func         <= func;
            item_reg.payload_byte <= payload_byte;
            item_reg.rx_byte      <= rx_byte;
        end
        if (advance)
        begin
            result_reg <= result_c;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tx_valid         = result_reg.tx_valid;
    assign tx_byte          = result_reg.tx_byte;
    assign tx_last          = result_reg.tx_last;
    assign need_payload     = result_reg.need_payload;
    assign status           = result_reg.status;
    assign success_count    = result_reg.success_count;
    assign total_errors     = result_reg.total_errors;
    assign last_error_block = result_reg.last_error_block;
    assign last_error_run   = result_reg.last_error_run;

    `XCS_ASSERT_IMP(a_last_needs_valid, out_valid_reg && result_reg.tx_last, result_reg.tx_valid, "tx_last without tx_valid")
    `XCS_ASSERT_IMP(a_tx_while_busy, out_valid_reg && result_reg.tx_valid, result_reg.status == STATUS_BUSY, "byte sent while not busy")
    `XCS_ASSERT_IMP(a_load_while_busy, out_valid_reg && result_reg.need_payload, result_reg.status == STATUS_BUSY, "payload request while not busy")

endmodule

### tb/sv/tb_xmodem_checksum_sender_core.sv
// ----------------------------------------------------------------------------
// XMODEM checksum sender - core testbench
// Feeds start, payload, received-byte, transmit-slot and link-error events
// through the valid/ready input and predicts every report with an in-bench
// protocol model. The input side idles in random bursts and the report side
// stalls on its own pattern. Each report is compared field by field in
// arrival order.
// ----------------------------------------------------------------------------
module tb_xmodem_checksum_sender_core;
    import xcs_pkg::*;

    localparam int BLK            = BLOCK_DATA_BYTES_DEF;
    localparam int HDR_BYTES      = 3;
    localparam int TOTAL_EVENTS   = 550;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 150;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int NO_CAP         = 100000;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_TRANSFER_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [FUNC_W-1:0]     func         = FUNC_START;
    logic [BYTE_W-1:0]     payload_byte = '0;
    logic [BYTE_W-1:0]     rx_byte      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  tx_valid;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  tx_last;
    logic                  need_payload;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    success_count;
    logic [TOTAL_W-1:0]    total_errors;
    logic [COUNT_W-1:0]    last_error_block;
    logic [RUN_W-1:0]      last_error_run;

    xmodem_checksum_sender_core DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    xcs_item_t   core_events[$];
    xcs_result_t predicted_reports[$];
    int unsigned events_queued     = 0;
    int unsigned events_accepted   = 0;
    int unsigned reports_checked   = 0;
    int unsigned transfers_started = 0;
    int unsigned mismatches        = 0;
    int unsigned outcome_tally [0:7];

    // protocol model state
    logic [TLEN_W-1:0]  cfg_len   = '0;
    logic [RUN_W-1:0]   cfg_limit = ERROR_LIMIT_RESET;
    phase_t             ph        = PH_IDLE;
    logic [BYTE_W-1:0]  block_store [0:BLK-1];
    logic [COUNT_W-1:0] blk_num   = '0;
    logic [TLEN_W-1:0]  remaining = '0;
    logic [7:0]         chunk     = '0;
    logic [7:0]         load_pos  = '0;
    logic [7:0]         send_pos  = '0;
    logic [BYTE_W-1:0]  csum      = '0;
    logic [RUN_W-1:0]   err_run   = '0;
    logic [COUNT_W-1:0] acked     = '0;
    logic [TOTAL_W-1:0] naks      = '0;
    logic [COUNT_W-1:0] nak_blk   = '0;
    logic [RUN_W-1:0]   nak_run   = '0;
    logic [STATUS_W-1:0] end_code = STATUS_BUSY;

    function automatic void end_transfer(input logic [STATUS_W-1:0] code);
        end_code = code;
        ph = PH_IDLE;
        outcome_tally[code]++;
    endfunction

    function automatic void start_load();
        chunk = (remaining >= BLK) ? 8'(BLK) : remaining[7:0];
        load_pos = '0;
        ph = PH_LOAD;
    endfunction

    function automatic void start_send();
        send_pos = '0;
        csum = '0;
        ph = PH_SEND;
    endfunction

    function automatic void bump_run();
        if (err_run != '1)
            err_run = err_run + 1'b1;
    endfunction

    function automatic xcs_result_t xmodem_sender_step(input xcs_item_t ev);
        xcs_result_t r;
        int unsigned pos;
        r = '0;
        case (ev.func)
            FUNC_START:
            begin
                end_code = STATUS_BUSY;
                acked = '0;
                naks = '0;
                nak_blk = '0;
                nak_run = '0;
                err_run = '0;
                blk_num = '0;
                remaining = cfg_len;
                if (remaining == 0)
                    end_transfer(STATUS_BAD_LEN);
                else
                    ph = PH_WAIT_NAK;
            end
            FUNC_PAYLOAD:
            begin
                if (ph == PH_LOAD)
                begin
                    if (load_pos < chunk)
                        block_store[load_pos] = ev.payload_byte;
                    load_pos = load_pos + 1'b1;
                    if (load_pos >= chunk)
                        start_send();
                end
            end
            FUNC_RX_BYTE:
            begin
                case (ph)
                    PH_WAIT_NAK:
                    begin
                        if (ev.rx_byte == CH_NAK)
                        begin
                            blk_num = COUNT_W'(1);
                            err_run = '0;
                            start_load();
                        end
                        else
                        begin
                            bump_run();
                            if (err_run > cfg_limit)
                                end_transfer(STATUS_TX_ERROR);
                        end
                    end
                    PH_WAIT_RESP:
                    begin
                        if (ev.rx_byte == CH_ACK)
                        begin
                            acked = acked + 1'b1;
                            blk_num = blk_num + 1'b1;
                            remaining = remaining - chunk;
                            err_run = '0;
                            if (remaining == 0)
                                ph = PH_EOT_SEND;
                            else
                                start_load();
                        end
                        else if (ev.rx_byte == CH_CAN)
                            ph = PH_CAN_SEEN;
                        else if (ev.rx_byte == CH_NAK)
                        begin
                            bump_run();
                            if (naks != '1)
                                naks = naks + 1'b1;
                            nak_blk = blk_num;
                            nak_run = err_run;
                            if (err_run > cfg_limit)
                                end_transfer(STATUS_TX_ERROR);
                            else
                                start_send();
                        end
                    end
                    PH_CAN_SEEN:
                    begin
                        if (ev.rx_byte == CH_CAN)
                            end_transfer(STATUS_CANCELLED);
                        else
                            start_send();
                    end
                    PH_EOT_WAIT:
                    begin
                        if (ev.rx_byte == CH_ACK)
                            end_transfer(STATUS_DONE);
                        else
                            ph = PH_EOT_SEND;
                    end
                    default: ;
                endcase
            end
            FUNC_TX_SLOT:
            begin
                if (ph == PH_SEND)
                begin
                    r.tx_valid = 1'b1;
                    pos = send_pos;
                    if (pos == 0)
                        r.tx_byte = CH_SOH;
                    else if (pos == 1)
                        r.tx_byte = blk_num[7:0];
                    else if (pos == 2)
                        r.tx_byte = ~blk_num[7:0];
                    else if (pos < HDR_BYTES + BLK)
                    begin
                        r.tx_byte = (pos - HDR_BYTES < chunk) ? block_store[pos - HDR_BYTES]
                                                             : 8'h00;
                        csum = csum + r.tx_byte;
                    end
                    else
                    begin
                        r.tx_byte = csum;
                        r.tx_last = 1'b1;
                    end
                    if (r.tx_last)
                        ph = PH_WAIT_RESP;
                    else
                        send_pos = send_pos + 1'b1;
                end
                else if (ph == PH_EOT_SEND)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = CH_EOT;
                    r.tx_last = 1'b1;
                    ph = PH_EOT_WAIT;
                end
            end
            FUNC_LINK_ERR:
            begin
                if (ph != PH_IDLE && ph != PH_WAIT_NAK)
                    end_transfer(STATUS_TX_ERROR);
            end
            default: ;
        endcase
        r.need_payload = (ph == PH_LOAD);
        r.status = (ph == PH_IDLE) ? end_code : STATUS_BUSY;
        r.success_count = acked;
        r.total_errors = naks;
        r.last_error_block = nak_blk;
        r.last_error_run = nak_run;
        return r;
    endfunction

    // event generation
    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic void add_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] p,
                                      input logic [BYTE_W-1:0] r);
        xcs_item_t ev;
        ev.func = f;
        ev.payload_byte = p;
        ev.rx_byte = r;
        core_events.push_back(ev);
        events_queued++;
    endfunction

    function automatic void add_rx(input logic [BYTE_W-1:0] b);
        add_event(FUNC_RX_BYTE, rand_byte(), b);
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte_except(input logic [BYTE_W-1:0] a,
                                                             input logic [BYTE_W-1:0] b,
                                                             input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        do
            v = rand_byte();
        while (v == a || v == b || v == c);
        return v;
    endfunction

    function automatic void add_ignored(input bit rx_ok, input bit pay_ok, input bit slot_ok);
        int unsigned pick;
        do
            pick = $urandom_range(0, 3);
        while ((pick == 0 && !rx_ok) || (pick == 1 && !pay_ok) || (pick == 2 && !slot_ok));
        case (pick)
            0: add_event(FUNC_RX_BYTE, rand_byte(), rand_byte());
            1: add_event(FUNC_PAYLOAD, rand_byte(), rand_byte());
            2: add_event(FUNC_TX_SLOT, rand_byte(), rand_byte());
            default: add_event(FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)),
                               rand_byte(), rand_byte());
        endcase
    endfunction

    task automatic queue_transfer(input int forced_noise, input int unsigned cap,
                                  input bit may_abandon);
        int unsigned noise, left, chunk_len, blocks, run, pick, k;
        bit resend, acked_block;
        transfers_started++;
        add_event(FUNC_START, rand_byte(), rand_byte());
        if (cfg_len == 0)
            return;
        if (forced_noise >= 0)
            noise = forced_noise;
        else if (cfg_limit < 16 && $urandom_range(0, 5) == 0)
            noise = cfg_limit + 1;
        else
            noise = $urandom_range(0, 2);
        for (k = 0; k < noise; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_event(FUNC_LINK_ERR, rand_byte(), rand_byte());
            add_rx(random_byte_except(CH_NAK, CH_NAK, CH_NAK));
        end
        if ((noise > 255 ? 255 : noise) > cfg_limit)
            return;
        add_rx(CH_NAK);
        left = cfg_len;
        blocks = 0;
        run = 0;
        while (left != 0)
        begin
            if (blocks == cap)
            begin
                add_event(FUNC_LINK_ERR, rand_byte(), rand_byte());
                return;
            end
            chunk_len = (left < BLK) ? left : BLK;
            for (k = 0; k < chunk_len; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    add_ignored(1'b1, 1'b0, 1'b1);
                add_event(FUNC_PAYLOAD, rand_byte(), rand_byte());
            end
            acked_block = 1'b0;
            while (!acked_block)
            begin
                for (k = 0; k < HDR_BYTES + BLK + 1; k++)
                begin
                    if ($urandom_range(0, 31) == 0)
                        add_ignored(1'b1, 1'b1, 1'b0);
                    add_event(FUNC_TX_SLOT, rand_byte(), rand_byte());
                end
                resend = 1'b0;
                while (!resend && !acked_block)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 62)
                    begin
                        add_rx(CH_ACK);
                        run = 0;
                        left = left - chunk_len;
                        blocks++;
                        acked_block = 1'b1;
                    end
                    else if (pick < 76)
                    begin
                        add_rx(CH_NAK);
                        if (run < 255)
                            run++;
                        if (run > cfg_limit)
                            return;
                        resend = 1'b1;
                    end
                    else if (pick < 82)
                    begin
                        add_rx(CH_CAN);
                        add_rx(random_byte_except(CH_CAN, CH_CAN, CH_CAN));
                        resend = 1'b1;
                    end
                    else if (pick < 88)
                        add_rx(random_byte_except(CH_ACK, CH_NAK, CH_CAN));
                    else if (pick < 91)
                    begin
                        add_rx(CH_CAN);
                        add_rx(CH_CAN);
                        return;
                    end
                    else if (pick < 94)
                    begin
                        add_event(FUNC_LINK_ERR, rand_byte(), rand_byte());
                        return;
                    end
                    else if (pick < 96)
                    begin
                        if (may_abandon)
                            return;
                    end
                    else
                        add_ignored(1'b0, 1'b1, 1'b1);
                end
            end
        end
        // repeat EOT until it is acknowledged
        for (k = 0; k < 4; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_ignored(1'b1, 1'b1, 1'b0);
            add_event(FUNC_TX_SLOT, rand_byte(), rand_byte());
            if (k == 3 || $urandom_range(0, 2) != 0)
            begin
                add_rx(CH_ACK);
                break;
            end
            add_rx(random_byte_except(CH_ACK, CH_ACK, CH_ACK));
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (core_events.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_TRANSFER_LENGTH)
            cfg_len = val;
        else
            cfg_limit = val[RUN_W-1:0];
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] len, input logic [RUN_W-1:0] limit,
                             input int forced_noise, input int unsigned cap,
                             input int unsigned sessions);
        int unsigned s;
        settle();
        write_reg(CFG_TRANSFER_LENGTH, len);
        write_reg(CFG_ERROR_LIMIT, CFG_DATA_W'(limit));
        for (s = 0; s < sessions; s++)
        begin
            queue_transfer(s == 0 ? forced_noise : -1, cap, s + 1 < sessions);
            repeat ($urandom_range(0, 2)) add_ignored(1'b1, 1'b1, 1'b1);
        end
    endtask

    // input driver: bursts with random gaps
    xcs_item_t   on_bus;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted_reports.push_back(xmodem_sender_step(on_bus));
                events_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || core_events.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    on_bus = core_events.pop_front();
                    func         <= on_bus.func;
                    payload_byte <= on_bus.payload_byte;
                    rx_byte      <= on_bus.rx_byte;
                    in_valid     <= 1'b1;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                          : $urandom_range(10, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // report side: own stall pattern plus one long hold-off
    logic [31:0] ready_pattern = '0;
    int unsigned pattern_left  = 0;
    int unsigned ready_mode    = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && reports_checked >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                ready_pattern = $urandom;
                pattern_left = $urandom_range(16, 96);
                ready_mode = $urandom_range(0, 3);
            end
            pattern_left--;
            ready_pattern = {ready_pattern[30:0], ready_pattern[31]};
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ready_pattern[0];
                2: out_ready <= ready_pattern[0] | ready_pattern[7];
                default: out_ready <= ready_pattern[0] & ready_pattern[7];
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    xcs_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("report with nothing outstanding: tx_byte %0h status %0d",
                       tx_byte, status);
                mismatches++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
                check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
                check_field("tx_last", 32'(want.tx_last), 32'(tx_last));
                check_field("need_payload", 32'(want.need_payload), 32'(need_payload));
                check_field("status", 32'(want.status), 32'(status));
                check_field("success_count", 32'(want.success_count), 32'(success_count));
                check_field("total_errors", 32'(want.total_errors), 32'(total_errors));
                check_field("last_error_block", 32'(want.last_error_block),
                            32'(last_error_block));
                check_field("last_error_run", 32'(want.last_error_run),
                            32'(last_error_run));
            end
            reports_checked++;
        end
    end

    initial
    begin
        int unsigned c;
        for (c = 0; c < CYCLE_LIMIT; c++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d reports outstanding", CYCLE_LIMIT,
                 predicted_reports.size());
        $display("** xmodem_checksum_sender_core: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned rnd_len, rnd_limit;
        for (int i = 0; i < 8; i++)
            outcome_tally[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // idle ignores, spare codes and a zero-length start
        add_event(FUNC_SPARE_LO, 8'hFF, 8'hFF);
        add_event(FUNC_SPARE_LO + 3'd1, 8'h00, 8'h00);
        add_event(FUNC_SPARE_HI, 8'hA5, 8'h5A);
        add_rx(CH_NAK);
        add_event(FUNC_TX_SLOT, 8'h00, 8'h00);
        add_event(FUNC_PAYLOAD, 8'hFF, 8'h00);
        add_event(FUNC_LINK_ERR, 8'h00, 8'h00);
        add_event(FUNC_START, 8'h00, 8'h00);
        settle();
        write_reg(CFG_TRANSFER_LENGTH, 24'd3);
        write_reg(CFG_ERROR_LIMIT, '0);
        add_event(FUNC_START, 8'h00, 8'h00);
        add_rx(8'hFF);
        add_event(FUNC_START, 8'hFF, 8'hFF);
        add_event(FUNC_LINK_ERR, 8'h00, 8'h00);
        add_rx(CH_NAK);
        add_event(FUNC_PAYLOAD, 8'h00, 8'h00);
        add_event(FUNC_PAYLOAD, 8'hFF, 8'hFF);
        add_event(FUNC_LINK_ERR, 8'h00, 8'h00);
        add_event(FUNC_START, 8'h00, 8'h00);
        add_rx(CH_NAK);
        add_event(FUNC_PAYLOAD, 8'h80, 8'h00);
        add_event(FUNC_START, 8'h00, 8'h00);
        add_rx(8'h00);

        // saturating error run on a full-length transfer, cut short by a link error
        run_phase(24'hFFFFFF, 8'hFF, 257, 0, 1);
        while (events_queued < TOTAL_EVENTS)
        begin
            rnd_len = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(BLK + 1, BLK + 40);
            rnd_limit = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 12);
            run_phase(24'(rnd_len), 8'(rnd_limit), -1, NO_CAP, $urandom_range(1, 2));
        end
        settle();

        if (predicted_reports.size() != 0)
        begin
            $error("%0d reports never arrived", predicted_reports.size());
            mismatches += predicted_reports.size();
        end
        $display("%0d events over %0d transfers, %0d reports checked, %0d mismatches",
                 events_accepted, transfers_started, reports_checked, mismatches);
        $display("endings: %0d complete, %0d bad length, %0d failed, %0d cancelled",
                 outcome_tally[STATUS_DONE], outcome_tally[STATUS_BAD_LEN],
                 outcome_tally[STATUS_TX_ERROR], outcome_tally[STATUS_CANCELLED]);
        if (mismatches == 0)
            $display("** xmodem_checksum_sender_core: PASSED **");
        else
            $display("** xmodem_checksum_sender_core: FAILED **");
        $finish;
    end

endmodule
